// File: sv/frc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// frc_pkg
// Shared types, codes and constants of the Fenwick range counter.
// ----------------------------------------------------------------------------
package frc_pkg;

    localparam int TREE_SIZE_DEF = 131072;
    localparam int COORD_W       = 17;
    localparam int COUNT_W       = 32;
    localparam int REQ_W         = 2;
    localparam int STAT_W        = 2;

    typedef enum logic [REQ_W-1:0] {
        REQ_INSERT = 2'd0,
        REQ_COUNT  = 2'd1,
        REQ_CLEAR  = 2'd2
    } t_req_type;

    localparam logic [STAT_W-1:0] ST_OK       = 2'd0;
    localparam logic [STAT_W-1:0] ST_FULL     = 2'd1;
    localparam logic [STAT_W-1:0] ST_REVERSED = 2'd2;

    typedef enum logic [2:0] {
        S_INIT,
        S_IDLE,
        S_INS,
        S_HI,
        S_LO,
        S_CLR,
        S_DRAIN
    } t_state;

    // controller -> datapath
    typedef struct packed {
        logic load;       // latch request, set up first walk
        logic step_ins;   // one node of the insert walk
        logic step_hi;    // one node of the upper prefix walk
        logic step_lo;    // one node of the lower prefix walk
        logic clr_step;   // zero one store entry
        logic emit;       // present the result
    } t_dp_cmd;

    // datapath -> controller
    typedef struct packed {
        logic ins_ok;     // insert walks the tree
        logic reversed;   // low bound above high bound
        logic ins_last;   // insert walk leaves the tree after this node
        logic walk_last;  // prefix walk reaches zero after this node
        logic clr_last;   // last entry of the clearing sweep
    } t_dp_stat;

endpackage

// File: sv/frc_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// frc_ram
// Generic simple dual-port RAM: one write port, one registered read port.
// ----------------------------------------------------------------------------
module frc_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// File: sv/frc_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// frc_datapath
// Node index walker, node store, accumulator, point total and result
// registers. Node addresses follow from the index alone, so one node is
// issued per cycle; read data comes back in the next cycle.
// ----------------------------------------------------------------------------
module frc_datapath
    import frc_pkg::*;
#(
    parameter int TREE_SIZE = TREE_SIZE_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  t_dp_cmd             i_cmd,
    output t_dp_stat            o_stat,
    input  logic [REQ_W-1:0]    i_req_type,
    input  logic [COORD_W-1:0]  i_point_y,
    input  logic [COORD_W-1:0]  i_range_low,
    input  logic [COORD_W-1:0]  i_range_high,
    output logic                o_done,
    output logic [COUNT_W-1:0]  o_point_count,
    output logic [STAT_W-1:0]   o_status
);

    localparam int IW = $clog2(TREE_SIZE);
    localparam int KW = IW + 1;
    localparam logic [31:0] KMAX   = 32'(TREE_SIZE - 1);
    localparam logic [31:0] YMAX   = 32'(TREE_SIZE - 2);
    localparam logic [KW-1:0] KEND = KW'(TREE_SIZE);

    logic [KW-1:0]      r_k, n_k;
    logic [IW-1:0]      r_lo, n_lo;
    logic [COUNT_W-1:0] r_acc, n_acc;
    logic [COUNT_W-1:0] r_total, n_total;
    logic [IW-1:0]      r_clr_addr, n_clr_addr;
    logic               r_pend, n_pend;
    logic               r_pend_ins, n_pend_ins;
    logic               r_pend_sub, n_pend_sub;
    logic [IW-1:0]      r_pend_addr, n_pend_addr;
    logic [STAT_W-1:0]  r_stat, n_stat;
    logic               r_done, n_done;
    logic [COUNT_W-1:0] r_count, n_count;
    logic [STAT_W-1:0]  r_status, n_status;

    logic [COUNT_W-1:0] rd_data;
    logic               we;
    logic [IW-1:0]      waddr;
    logic [COUNT_W-1:0] wdata;

    logic               full;
    logic [31:0]        hi_bound;
    logic [31:0]        lo_bound;
    logic [KW-1:0]      k_ins_next;
    logic [KW-1:0]      k_pre_next;
    logic [COUNT_W-1:0] acc_upd;

    assign full       = (r_total == '1);
    assign hi_bound   = 32'(i_range_high) + 32'd1;
    assign lo_bound   = 32'(i_range_low);
    assign k_ins_next = r_k + (r_k & (~r_k + KW'(1)));
    assign k_pre_next = r_k & (r_k - KW'(1));

    assign o_stat.ins_ok    = !full && (32'(i_point_y) <= YMAX);
    assign o_stat.reversed  = (i_range_low > i_range_high);
    assign o_stat.ins_last  = (k_ins_next >= KEND);
    assign o_stat.walk_last = (k_pre_next == '0);
    assign o_stat.clr_last  = (r_clr_addr == IW'(TREE_SIZE - 1));

    // pending node read folds into the sum; insert reads go back +1
    always_comb begin
        acc_upd = r_acc;
        if (r_pend && !r_pend_ins) begin
            acc_upd = r_pend_sub ? (r_acc - rd_data) : (r_acc + rd_data);
        end
    end

    assign we    = i_cmd.clr_step || (r_pend && r_pend_ins);
    assign waddr = i_cmd.clr_step ? r_clr_addr : r_pend_addr;
    assign wdata = i_cmd.clr_step ? '0 : (rd_data + COUNT_W'(1));

    frc_ram #(
        .WIDTH (COUNT_W),
        .DEPTH (TREE_SIZE)
    ) u_nodes (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_raddr (r_k[IW-1:0]),
        .o_rdata (rd_data)
    );

    always_comb begin
        n_k         = r_k;
        n_lo        = r_lo;
        n_acc       = acc_upd;
        n_total     = r_total;
        n_clr_addr  = r_clr_addr;
        n_pend      = 1'b0;
        n_pend_ins  = 1'b0;
        n_pend_sub  = 1'b0;
        n_pend_addr = r_k[IW-1:0];
        n_stat      = r_stat;
        n_done      = 1'b0;
        n_count     = r_count;
        n_status    = r_status;

        if (i_cmd.load) begin
            n_acc  = '0;
            n_stat = ST_OK;
            n_lo   = (lo_bound > KMAX) ? KMAX[IW-1:0] : lo_bound[IW-1:0];
            case (t_req_type'(i_req_type))
                REQ_INSERT: begin
                    n_k = KW'(i_point_y) + KW'(1);
                    if (full) begin
                        n_stat = ST_FULL;
                    end else if (o_stat.ins_ok) begin
                        n_total = r_total + COUNT_W'(1);
                    end
                end
                REQ_COUNT: begin
                    n_k = (hi_bound > KMAX) ? KMAX[KW-1:0] : hi_bound[KW-1:0];
                    if (o_stat.reversed) begin
                        n_stat = ST_REVERSED;
                    end
                end
                default: begin
                    n_k = '0;
                end
            endcase
        end

        if (i_cmd.step_ins) begin
            n_pend     = 1'b1;
            n_pend_ins = 1'b1;
            n_k        = k_ins_next;
        end

        if (i_cmd.step_hi || i_cmd.step_lo) begin
            n_pend     = (r_k != '0);
            n_pend_sub = i_cmd.step_lo;
            n_k        = (i_cmd.step_hi && o_stat.walk_last) ? KW'(r_lo) : k_pre_next;
        end

        if (i_cmd.clr_step) begin
            n_total    = '0;
            n_clr_addr = o_stat.clr_last ? '0 : (r_clr_addr + IW'(1));
        end

        if (i_cmd.emit) begin
            n_done   = 1'b1;
            n_count  = acc_upd;
            n_status = r_stat;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_total    <= '0;
            r_clr_addr <= '0;
            r_pend     <= 1'b0;
            r_done     <= 1'b0;
        end else begin
            r_total    <= n_total;
            r_clr_addr <= n_clr_addr;
            r_pend     <= n_pend;
            r_done     <= n_done;
        end
    end

    always_ff @(posedge i_clk) begin
        r_k         <= n_k;
        r_lo        <= n_lo;
        r_acc       <= n_acc;
        r_pend_ins  <= n_pend_ins;
        r_pend_sub  <= n_pend_sub;
        r_pend_addr <= n_pend_addr;
        r_stat      <= n_stat;
        r_count     <= n_count;
        r_status    <= n_status;
    end

    assign o_done        = r_done;
    assign o_point_count = r_count;
    assign o_status      = r_status;

endmodule

// File: sv/frc_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// frc_ctrl
// Request sequencer: start-up clear sweep, insert walk, two prefix walks,
// clear sweep, and the result cycle.
// ----------------------------------------------------------------------------
module frc_ctrl
    import frc_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [REQ_W-1:0] i_req_type,
    input  t_dp_stat         i_stat,
    output t_dp_cmd          o_cmd,
    output logic             o_busy
);

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_INIT;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_INIT: begin
                if (i_stat.clr_last) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (i_start) begin
                    case (t_req_type'(i_req_type))
                        REQ_INSERT: n_state = i_stat.ins_ok ? S_INS : S_DRAIN;
                        REQ_COUNT:  n_state = i_stat.reversed ? S_DRAIN : S_HI;
                        REQ_CLEAR:  n_state = S_CLR;
                        default:    n_state = S_DRAIN;
                    endcase
                end
            end
            S_INS: begin
                if (i_stat.ins_last) n_state = S_DRAIN;
            end
            S_HI: begin
                if (i_stat.walk_last) n_state = S_LO;
            end
            S_LO: begin
                if (i_stat.walk_last) n_state = S_DRAIN;
            end
            S_CLR: begin
                if (i_stat.clr_last) n_state = S_DRAIN;
            end
            S_DRAIN: begin
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_INIT;
            end
        endcase
    end

    always_comb begin
        o_cmd  = '0;
        o_busy = 1'b1;
        case (r_state)
            S_INIT:  o_cmd.clr_step = 1'b1;
            S_IDLE: begin
                o_busy     = 1'b0;
                o_cmd.load = i_start;
            end
            S_INS:   o_cmd.step_ins = 1'b1;
            S_HI:    o_cmd.step_hi  = 1'b1;
            S_LO:    o_cmd.step_lo  = 1'b1;
            S_CLR:   o_cmd.clr_step = 1'b1;
            S_DRAIN: o_cmd.emit     = 1'b1;
            default: o_cmd = '0;
        endcase
    end

endmodule

// File: sv/fenwick_range_counter.sv
`timescale 1ns / 1ps
// One request at a time; the node RAM read port visits one node per cycle.
// Reset clears the node store in a sweep over every entry, busy high.
// The result strobe lasts one cycle; the receiver cannot stall.
// ----------------------------------------------------------------------------
// fenwick_range_counter
// Binary indexed tree of point counts with insert, range count and clear.
// ----------------------------------------------------------------------------
module fenwick_range_counter
    import frc_pkg::*;
#(
    parameter int TREE_SIZE = TREE_SIZE_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  logic [REQ_W-1:0]   i_req_type,
    input  logic [COORD_W-1:0] i_point_y,
    input  logic [COORD_W-1:0] i_range_low,
    input  logic [COORD_W-1:0] i_range_high,
    output logic               o_done,
    output logic [COUNT_W-1:0] o_point_count,
    output logic [STAT_W-1:0]  o_status
);

    t_dp_cmd  cmd;
    t_dp_stat stat;

    frc_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (start),
        .i_req_type (i_req_type),
        .i_stat     (stat),
        .o_cmd      (cmd),
        .o_busy     (busy)
    );

    frc_datapath #(
        .TREE_SIZE (TREE_SIZE)
    ) u_datapath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .o_stat        (stat),
        .i_req_type    (i_req_type),
        .i_point_y     (i_point_y),
        .i_range_low   (i_range_low),
        .i_range_high  (i_range_high),
        .o_done        (o_done),
        .o_point_count (o_point_count),
        .o_status      (o_status)
    );

endmodule

// File: sim/fenwick_range_counter_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fenwick_range_counter_tb
// Self-checking bench for the Fenwick range counter. Directed corner requests,
// a store clear, a drained pause and a long random mix of inserts, range
// counts, clears and unknown requests are sent with random gaps. A local
// tree of point counts predicts every result. Each result is checked field
// by field, in order.
// ----------------------------------------------------------------------------
module fenwick_range_counter_tb;
    import frc_pkg::*;

    localparam int TREE_N       = TREE_SIZE_DEF;
    localparam int STALL_LIMIT  = 4 * TREE_N + 1000;      // clear sweep dominates
    localparam int DRAIN_CYCLES = 2 * $clog2(TREE_N) + 16;
    localparam int RANDOM_ITEMS = 1700;
    localparam int MAX_REPORTS  = 10;

    localparam logic [REQ_W-1:0]   REQ_UNKNOWN = 2'd3;
    localparam logic [COORD_W-1:0] COORD_ALL1  = '1;
    localparam logic [COORD_W-1:0] COORD_TOP   = COORD_W'(TREE_N - 2);  // last insertable

    typedef struct {
        logic [COUNT_W-1:0] count;
        logic [STAT_W-1:0]  status;
    } t_range_result;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               start = 1'b0;
    logic               busy;
    logic [REQ_W-1:0]   i_req_type = '0;
    logic [COORD_W-1:0] i_point_y = '0;
    logic [COORD_W-1:0] i_range_low = '0;
    logic [COORD_W-1:0] i_range_high = '0;
    logic               o_done;
    logic [COUNT_W-1:0] o_point_count;
    logic [STAT_W-1:0]  o_status;

    // local copy of the counting tree
    logic [COUNT_W-1:0] tree_nodes [TREE_N];
    logic [COUNT_W-1:0] stored_points;

    t_range_result pending_results[$];

    int  mismatches   = 0;
    int  n_results    = 0;
    int  n_inserts    = 0;
    int  n_dropped    = 0;
    int  n_counts     = 0;
    int  n_nonzero    = 0;
    int  n_reversed   = 0;
    int  n_clears     = 0;
    int  n_unknown    = 0;
    int  stall_cycles = 0;
    bit  no_idle      = 1'b0;

    fenwick_range_counter dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .start         (start),
        .busy          (busy),
        .i_req_type    (i_req_type),
        .i_point_y     (i_point_y),
        .i_range_low   (i_range_low),
        .i_range_high  (i_range_high),
        .o_done        (o_done),
        .o_point_count (o_point_count),
        .o_status      (o_status)
    );

    initial begin
        forever #2 i_clk = ~i_clk;
    end

    // points with a coordinate below bound
    function automatic logic [COUNT_W-1:0] points_below(input int unsigned bound);
        int unsigned        k;
        logic [COUNT_W-1:0] acc;
        k   = (bound > TREE_N - 1) ? TREE_N - 1 : bound;
        acc = '0;
        while (k > 0) begin
            acc += tree_nodes[k];
            k &= k - 1;
        end
        return acc;
    endfunction

    function automatic t_range_result predict_request(input logic [REQ_W-1:0] kind,
                                                      input logic [COORD_W-1:0] y,
                                                      input logic [COORD_W-1:0] lo,
                                                      input logic [COORD_W-1:0] hi);
        t_range_result r;
        int unsigned   k;
        r.count  = '0;
        r.status = ST_OK;
        case (kind)
            REQ_INSERT: begin
                if (stored_points == '1) begin
                    r.status = ST_FULL;
                end else if (y <= COORD_TOP) begin
                    k = 32'(y) + 1;
                    while (k < TREE_N) begin
                        tree_nodes[k] += 1;
                        k += k & (~k + 1);
                    end
                    stored_points += 1;
                end
            end
            REQ_COUNT: begin
                if (lo > hi)
                    r.status = ST_REVERSED;
                else
                    r.count = points_below(32'(hi) + 1) - points_below(32'(lo));
            end
            REQ_CLEAR: begin
                foreach (tree_nodes[i]) tree_nodes[i] = '0;
                stored_points = '0;
            end
            default: ;
        endcase
        return r;
    endfunction

    function automatic int next_gap();
        int r;
        r = $urandom_range(0, 99);
        if (no_idle || r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    function automatic logic [COORD_W-1:0] any_coord();
        return COORD_W'($urandom);
    endfunction

    function automatic logic [COORD_W-1:0] pick_coord();
        int r;
        r = $urandom_range(0, 99);
        if (r < 30) return COORD_W'($urandom_range(0, 63));
        if (r < 45) return COORD_W'($urandom_range(TREE_N - 32, TREE_N - 1));
        if (r < 55) return COORD_W'($urandom_range(65500, 65600)); // around a power of two
        return COORD_W'($urandom_range(0, TREE_N - 1));
    endfunction

    // start stays high after acceptance when gap is 0, so the next request
    // must follow in the same step
    task automatic send_request(input logic [REQ_W-1:0] kind,
                                input logic [COORD_W-1:0] y,
                                input logic [COORD_W-1:0] lo,
                                input logic [COORD_W-1:0] hi,
                                input int gap);
        t_range_result exp;
        i_req_type   <= kind;
        i_point_y    <= y;
        i_range_low  <= lo;
        i_range_high <= hi;
        start        <= 1'b1;
        @(posedge i_clk);
        while (busy !== 1'b0) @(posedge i_clk);
        exp = predict_request(kind, y, lo, hi);
        pending_results.push_back(exp);
        case (kind)
            REQ_INSERT: begin
                n_inserts++;
                if (y > COORD_TOP) n_dropped++;
            end
            REQ_COUNT: begin
                n_counts++;
                if (exp.count != 0) n_nonzero++;
                if (exp.status == ST_REVERSED) n_reversed++;
            end
            REQ_CLEAR: n_clears++;
            default:   n_unknown++;
        endcase
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic send_rand(input logic [REQ_W-1:0] kind,
                             input logic [COORD_W-1:0] y,
                             input logic [COORD_W-1:0] lo,
                             input logic [COORD_W-1:0] hi);
        send_request(kind, y, lo, hi, next_gap());
    endtask

    task automatic wait_drained();
        start <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
    endtask

    task automatic test_corners();
        send_rand(REQ_COUNT, any_coord(), 0, COORD_ALL1);         // empty store
        send_rand(REQ_INSERT, 0, any_coord(), any_coord());
        send_rand(REQ_INSERT, COORD_TOP, any_coord(), any_coord());
        send_rand(REQ_INSERT, COORD_ALL1, any_coord(), any_coord()); // off the tree
        send_rand(REQ_INSERT, 65535, any_coord(), any_coord());
        send_rand(REQ_INSERT, 65536, any_coord(), any_coord());
        send_rand(REQ_INSERT, 0, COORD_ALL1, COORD_ALL1);
        send_rand(REQ_COUNT, COORD_ALL1, 0, 0);
        send_rand(REQ_COUNT, any_coord(), COORD_TOP, COORD_TOP);
        send_rand(REQ_COUNT, any_coord(), COORD_ALL1, COORD_ALL1);
        send_rand(REQ_COUNT, any_coord(), 0, COORD_ALL1);         // bound saturates
        send_rand(REQ_COUNT, any_coord(), 0, COORD_TOP);
        send_rand(REQ_COUNT, any_coord(), 1, 65535);
        send_rand(REQ_COUNT, any_coord(), 65536, COORD_TOP);
        send_rand(REQ_COUNT, any_coord(), 7, 6);                  // reversed
        send_rand(REQ_COUNT, any_coord(), COORD_ALL1, 0);
        send_rand(REQ_UNKNOWN, COORD_ALL1, COORD_ALL1, COORD_ALL1);
        send_rand(REQ_UNKNOWN, 0, 0, 0);
        send_rand(REQ_COUNT, any_coord(), 0, COORD_ALL1);
    endtask

    task automatic test_clear();
        repeat (4) send_rand(REQ_INSERT, pick_coord(), any_coord(), any_coord());
        send_rand(REQ_COUNT, any_coord(), 0, COORD_ALL1);
        send_rand(REQ_CLEAR, any_coord(), any_coord(), any_coord());
        send_rand(REQ_COUNT, any_coord(), 0, COORD_ALL1);
        send_rand(REQ_INSERT, 0, any_coord(), any_coord());
        send_rand(REQ_INSERT, COORD_TOP, any_coord(), any_coord());
        send_rand(REQ_COUNT, any_coord(), 0, COORD_ALL1);
    endtask

    // back-to-back burst, full drain, then resume
    task automatic test_idle_resume();
        no_idle = 1'b1;
        repeat (8) begin
            send_rand(REQ_INSERT, COORD_W'($urandom_range(0, 15)), any_coord(), any_coord());
        end
        send_rand(REQ_COUNT, any_coord(), 0, 15);
        wait_drained();
        repeat ($urandom_range(1, 20)) @(posedge i_clk);
        no_idle = 1'b0;
        send_rand(REQ_COUNT, any_coord(), 3, 12);
        send_rand(REQ_INSERT, 15, any_coord(), any_coord());
        send_rand(REQ_COUNT, any_coord(), 15, 15);
    endtask

    task automatic test_random_mix();
        int                 r;
        int                 clear_a;
        int                 clear_b;
        logic [COORD_W-1:0] a;
        logic [COORD_W-1:0] b;
        clear_a = $urandom_range(300, 800);
        clear_b = $urandom_range(1000, 1600);
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if (n % 100 == 0) no_idle = ($urandom_range(0, 2) == 0);
            if (n == clear_a || n == clear_b) begin
                send_rand(REQ_CLEAR, any_coord(), any_coord(), any_coord());
                continue;
            end
            r = $urandom_range(0, 99);
            if (r < 50) begin
                send_rand(REQ_INSERT, pick_coord(), any_coord(), any_coord());
            end else if (r < 96) begin
                a = pick_coord();
                b = pick_coord();
                r = $urandom_range(0, 99);
                if (r < 10)
                    send_rand(REQ_COUNT, any_coord(), a, b);       // either order
                else if (r < 20)
                    send_rand(REQ_COUNT, any_coord(), 0, a);
                else if (r < 30)
                    send_rand(REQ_COUNT, any_coord(), a, COORD_ALL1);
                else if (a <= b)
                    send_rand(REQ_COUNT, any_coord(), a, b);
                else
                    send_rand(REQ_COUNT, any_coord(), b, a);
            end else begin
                send_rand(REQ_UNKNOWN, any_coord(), any_coord(), any_coord());
            end
        end
        no_idle = 1'b0;
    endtask

    task automatic note_mismatch(input string field,
                                 input logic [COUNT_W-1:0] expv,
                                 input logic [COUNT_W-1:0] actv);
        mismatches++;
        if (mismatches <= MAX_REPORTS)
            $display("%0t: mismatch on %s, result %0d: expected %0d, got %0d",
                     $realtime, field, n_results, expv, actv);
    endtask

    always @(posedge i_clk) begin
        t_range_result exp;
        if (i_rst_n && o_done === 1'b1) begin
            n_results++;
            if (pending_results.size() == 0) begin
                note_mismatch("unexpected result", '0, o_point_count);
            end else begin
                exp = pending_results.pop_front();
                if (o_point_count !== exp.count)
                    note_mismatch("point_count", exp.count, o_point_count);
                if (o_status !== exp.status)
                    note_mismatch("status", COUNT_W'(exp.status), COUNT_W'(o_status));
            end
        end
    end

    // stall watchdog: any accepted request or result restarts the count
    always @(posedge i_clk) begin
        if ((start && busy === 1'b0) || o_done === 1'b1)
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= STALL_LIMIT) begin
            $display("Timeout after %0d cycles without progress", stall_cycles);
            $display("Verification failed");
            $finish;
        end
    end

    initial begin
        foreach (tree_nodes[i]) tree_nodes[i] = '0;
        stored_points = '0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_corners();
        test_clear();
        test_idle_resume();
        test_random_mix();

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Covered %0d inserts (%0d off the tree), %0d range counts",
                 n_inserts, n_dropped, n_counts);
        $display("(%0d nonzero, %0d reversed), %0d clears, %0d unknown; %0d checked, %0d bad.",
                 n_nonzero, n_reversed, n_clears, n_unknown, n_results, mismatches);
        if (mismatches == 0 && pending_results.size() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
